// File: src/hcbd_pkg.sv
package hcbd_pkg;

    localparam int HEADER_MAX = 64;
    localparam int SIZE_BITS  = 32;
    localparam int HC_BITS    = 7;
    localparam int BODY_BITS  = 32;
    localparam int SKIP_BITS  = 2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [SKIP_BITS-1:0] SKIP_BYTES = SKIP_BITS'(2);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [6:0] {
        PH_DIGITS = 7'b000_0001,
        PH_EXT    = 7'b000_0010,
        PH_DATA   = 7'b000_0100,
        PH_TERM   = 7'b000_1000,
        PH_LAST   = 7'b001_0000,
        PH_DONE   = 7'b010_0000,
        PH_ERROR  = 7'b100_0000
    } phase_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           data_byte;
        logic [BODY_BITS-1:0] body_total;
    } result_t;

endpackage

// File: src/hcbd_in_reg.sv
module hcbd_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       core_ready,
    output logic       core_fire,
    output logic [7:0] core_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       accept;

    assign core_fire = in_valid_reg && core_ready;
    assign s_ready   = !in_valid_reg || core_ready;
    assign accept    = s_valid && s_ready;
    assign core_byte = in_byte_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (core_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_in_byte;
        end
    end

endmodule

// File: src/hcbd_core.sv
module hcbd_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    output hcbd_pkg::result_t   res
);

    hcbd_pkg::phase_t                  phase_reg;
    hcbd_pkg::phase_t                  phase_next;
    hcbd_pkg::phase_t                  phase_work;
    logic [hcbd_pkg::SIZE_BITS-1:0]    remaining_reg;
    logic [hcbd_pkg::SIZE_BITS-1:0]    remaining_next;
    logic [hcbd_pkg::SIZE_BITS-1:0]    rem_work;
    logic [hcbd_pkg::HC_BITS-1:0]      header_count_reg;
    logic [hcbd_pkg::HC_BITS-1:0]      header_count_next;
    logic [hcbd_pkg::HC_BITS-1:0]      hc_inc;
    logic                              saw_cr_reg;
    logic                              saw_cr_next;
    logic [hcbd_pkg::SKIP_BITS-1:0]    skip_count_reg;
    logic [hcbd_pkg::SKIP_BITS-1:0]    skip_count_next;
    logic [hcbd_pkg::SKIP_BITS-1:0]    skip_dec;
    logic [hcbd_pkg::BODY_BITS-1:0]    body_count_reg;
    logic [hcbd_pkg::BODY_BITS-1:0]    body_count_next;
    logic                              is_digit;
    logic [3:0]                        digit;
    logic                              overflow;

    assign hc_inc   = header_count_reg + hcbd_pkg::HC_BITS'(1);
    assign skip_dec = skip_count_reg - hcbd_pkg::SKIP_BITS'(1);

    always_comb begin
        is_digit = 1'b0;
        digit    = 4'd0;
        if (in_byte inside {[8'h30:8'h39]}) begin
            is_digit = 1'b1;
            digit    = in_byte[3:0];
        end else if (in_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            is_digit = 1'b1;
            digit    = in_byte[3:0] + 4'd9;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        header_count_next = header_count_reg;
        saw_cr_next       = saw_cr_reg;
        skip_count_next   = skip_count_reg;
        body_count_next   = body_count_reg;
        phase_work        = phase_reg;
        rem_work          = remaining_reg;
        overflow          = 1'b0;
        res_valid         = 1'b0;
        res.kind          = hcbd_pkg::KIND_DATA;
        res.data_byte     = 8'd0;
        res.body_total    = '0;
        if (fire) begin
            case (phase_reg)
                hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_EXT: begin
                    header_count_next = hc_inc;
                    if (phase_reg == hcbd_pkg::PH_DIGITS) begin
                        if (is_digit) begin
                            if (remaining_reg[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                                overflow = 1'b1;
                            end else begin
                                rem_work = {remaining_reg[hcbd_pkg::SIZE_BITS-5:0], digit};
                            end
                        end else begin
                            phase_work = hcbd_pkg::PH_EXT;
                        end
                    end
                    if (overflow) begin
                        phase_next = hcbd_pkg::PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = hcbd_pkg::KIND_ERROR;
                    end else if (in_byte == hcbd_pkg::CHAR_LF && saw_cr_reg) begin
                        saw_cr_next       = 1'b0;
                        header_count_next = '0;
                        skip_count_next   = hcbd_pkg::SKIP_BYTES;
                        remaining_next    = rem_work;
                        phase_next        = (rem_work == '0) ? hcbd_pkg::PH_LAST
                                                             : hcbd_pkg::PH_DATA;
                    end else begin
                        remaining_next = rem_work;
                        phase_next     = phase_work;
                        saw_cr_next    = (in_byte == hcbd_pkg::CHAR_CR);
                        if (hc_inc >= hcbd_pkg::HC_BITS'(hcbd_pkg::HEADER_MAX)) begin
                            phase_next = hcbd_pkg::PH_ERROR;
                            res_valid  = 1'b1;
                            res.kind   = hcbd_pkg::KIND_ERROR;
                        end
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    remaining_next  = remaining_reg - hcbd_pkg::SIZE_BITS'(1);
                    body_count_next = body_count_reg + hcbd_pkg::BODY_BITS'(1);
                    if (remaining_next == '0) begin
                        phase_next      = hcbd_pkg::PH_TERM;
                        skip_count_next = hcbd_pkg::SKIP_BYTES;
                    end
                    res_valid     = 1'b1;
                    res.kind      = hcbd_pkg::KIND_DATA;
                    res.data_byte = in_byte;
                end
                hcbd_pkg::PH_TERM: begin
                    skip_count_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next        = hcbd_pkg::PH_DIGITS;
                        remaining_next    = '0;
                        header_count_next = '0;
                        saw_cr_next       = 1'b0;
                    end
                end
                hcbd_pkg::PH_LAST: begin
                    skip_count_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next     = hcbd_pkg::PH_DONE;
                        res_valid      = 1'b1;
                        res.kind       = hcbd_pkg::KIND_END;
                        res.body_total = body_count_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= hcbd_pkg::PH_DIGITS;
            remaining_reg    <= '0;
            header_count_reg <= '0;
            saw_cr_reg       <= 1'b0;
            skip_count_reg   <= '0;
            body_count_reg   <= '0;
        end else begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            header_count_reg <= header_count_next;
            saw_cr_reg       <= saw_cr_next;
            skip_count_reg   <= skip_count_next;
            body_count_reg   <= body_count_next;
        end
    end

endmodule

// File: src/hcbd_out_buf.sv
module hcbd_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  hcbd_pkg::result_t push_data,
    output logic              push_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output hcbd_pkg::result_t m_data
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    hcbd_pkg::result_t main_data_reg;
    hcbd_pkg::result_t main_data_next;
    hcbd_pkg::result_t skid_data_reg;
    hcbd_pkg::result_t skid_data_next;
    logic              pop;

    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_data_reg;
    assign pop        = main_valid_reg && m_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push_valid;
                main_data_next  = push_data;
            end
        end else if (push_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: src/http_chunked_body_decoder_unit.sv
// Channel   Handshake           Word contents
// s_        s_valid / s_ready   s_in_byte: one raw byte of the chunked body
// m_        m_valid / m_ready   m_kind, m_data_byte, m_body_total
//
// One byte per cycle sustained unless m_ stalls; a byte's word, if any, goes from the input
// register through decode logic with header state to a two-entry output buffer, then to m_.
// Reset (aresetn low, synchronous) returns to the start of a chunk header.
// A stalled m_ only blocks s_ once both output entries and the input register fill.
module http_chunked_body_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_body_total
);

    logic              core_ready;
    logic              core_fire;
    logic [7:0]        core_byte;
    logic              res_valid;
    hcbd_pkg::result_t res;
    hcbd_pkg::result_t m_data;

    hcbd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .core_ready (core_ready),
        .core_fire  (core_fire),
        .core_byte  (core_byte)
    );

    hcbd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (core_fire),
        .in_byte   (core_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    hcbd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (res_valid),
        .push_data  (res),
        .push_ready (core_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    assign m_kind       = m_data.kind;
    assign m_data_byte  = m_data.data_byte;
    assign m_body_total = m_data.body_total;

endmodule

// File: tb/sv/http_chunked_body_decoder_unit_test.sv
module http_chunked_body_decoder_unit_test;

    import hcbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam logic [63:0] SIZE_LIMIT = (64'd1 << SIZE_BITS) - 64'd1;

    typedef enum int {
        END_ZERO_CHUNK,
        END_LONG_HEADER,
        END_OVERFLOW
    } body_end_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [31:0] m_body_total;

    phase_t      ph;
    logic [31:0] rem;
    logic [6:0]  hcnt;
    logic        scr;
    logic [1:0]  skip;
    logic [31:0] bcnt;

    result_t     pending_words[$];
    result_t     want;

    bit          idle_en = 1'b1;
    int          gap_pct = 20;
    int          stall_pct = 12;
    int          bytes_sent = 0;
    int          words_seen = 0;
    int          chunks_sent = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    body_end_t   end_how;

    http_chunked_body_decoder_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_body_total (m_body_total)
    );

    always #10 aclk = ~aclk;

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
        if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h30 - 8'h07);
        if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h30 - 8'h07 - 8'h20);
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        if (lower) return 8'h61 + 8'(n) - 8'd10;
        return 8'h41 + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] ext_byte(input logic [7:0] prev, input bit first);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (first && hex_digit(b) >= 0) b = 8'($urandom_range(0, 255));
        if (prev == CHAR_CR && b == CHAR_LF) b = 8'h3B;
        return b;
    endfunction

    task automatic reset_decoder();
        ph   = PH_DIGITS;
        rem  = '0;
        hcnt = '0;
        scr  = 1'b0;
        skip = '0;
        bcnt = '0;
    endtask

    task automatic push_word(input kind_t k, input logic [7:0] d, input logic [31:0] t);
        result_t r;
        r.kind       = k;
        r.data_byte  = d;
        r.body_total = t;
        pending_words.push_back(r);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int          d;
        logic [3:0]  nib;
        logic [63:0] nxt;
        case (ph)
            PH_DIGITS, PH_EXT: begin
                d = hex_digit(b);
                hcnt = hcnt + 7'd1;
                if (ph == PH_DIGITS) begin
                    if (d >= 0) begin
                        nib = d[3:0];
                        nxt = {28'd0, rem, nib};
                        if (nxt > SIZE_LIMIT) begin
                            ph = PH_ERROR;
                            push_word(KIND_ERROR, 8'h00, 32'd0);
                            return;
                        end
                        rem = nxt[31:0];
                    end else begin
                        ph = PH_EXT;
                    end
                end
                if (b == CHAR_LF && scr) begin
                    scr  = 1'b0;
                    hcnt = '0;
                    skip = SKIP_BYTES;
                    ph   = (rem == 0) ? PH_LAST : PH_DATA;
                    return;
                end
                scr = (b == CHAR_CR);
                if (hcnt >= HEADER_MAX) begin
                    ph = PH_ERROR;
                    push_word(KIND_ERROR, 8'h00, 32'd0);
                end
            end
            PH_DATA: begin
                rem  = rem - 32'd1;
                bcnt = bcnt + 32'd1;
                if (rem == 0) begin
                    ph   = PH_TERM;
                    skip = SKIP_BYTES;
                end
                push_word(KIND_DATA, b, 32'd0);
            end
            PH_TERM: begin
                skip = skip - 2'd1;
                if (skip == 0) begin
                    ph   = PH_DIGITS;
                    rem  = '0;
                    hcnt = '0;
                    scr  = 1'b0;
                end
            end
            PH_LAST: begin
                skip = skip - 2'd1;
                if (skip == 0) begin
                    ph = PH_DONE;
                    push_word(KIND_END, 8'h00, bcnt);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic send_chunk(input int size, input bit full_hdr);
        logic [7:0]  hdr[$];
        logic [31:0] sz;
        int          top;
        int          ext_len;
        sz = size;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) hdr.push_back(8'h30);
        end
        top = 7;
        while (top > 0 && sz[top*4 +: 4] == 4'd0) top--;
        for (int i = top; i >= 0; i--)
            hdr.push_back(hex_char(sz[i*4 +: 4], 1'($urandom_range(0, 1))));
        if (full_hdr) ext_len = HEADER_MAX - 2 - hdr.size();
        else ext_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
        for (int i = 0; i < ext_len; i++) hdr.push_back(ext_byte(hdr[$], i == 0));
        hdr.push_back(CHAR_CR);
        hdr.push_back(CHAR_LF);
        foreach (hdr[i]) send_byte(hdr[i]);
        repeat (size) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) begin
            repeat (2) send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_crlf();
        end
        chunks_sent++;
    endtask

    task automatic test_minimal_chunk();
        send_text("1");
        send_crlf();
        send_byte(8'h00);
        send_crlf();
    endtask

    task automatic test_extension_digits();
        send_text("2;7");
        send_crlf();
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_text("ZZ");
    endtask

    task automatic test_lone_cr_bare_lf();
        send_text("1");
        send_byte(CHAR_CR);
        send_text("A");
        send_byte(CHAR_LF);
        send_crlf();
        send_byte(CHAR_CR);
        send_crlf();
    endtask

    task automatic test_full_length_header();
        send_chunk(5, 1'b1);
    endtask

    task automatic test_random_chunks(input int target);
        int size;
        while (bytes_sent < target) begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            case ($urandom_range(0, 19))
                0:       size = $urandom_range(300, 600);
                1, 2:    size = $urandom_range(17, 299);
                default: size = $urandom_range(1, 16);
            endcase
            if (size > target - bytes_sent) size = target - bytes_sent;
            send_chunk(size, $urandom_range(0, 24) == 0);
        end
    endtask

    task automatic test_body_end();
        logic [7:0] b;
        end_how = ($urandom_range(0, 3) < 2) ? END_ZERO_CHUNK :
                  ($urandom_range(0, 1) ? END_LONG_HEADER : END_OVERFLOW);
        case (end_how)
            END_ZERO_CHUNK: begin
                if ($urandom_range(0, 1)) send_text("0");
                else send_text("000;last");
                send_crlf();
                repeat (2) send_byte(8'($urandom_range(0, 255)));
            end
            END_LONG_HEADER: begin
                b = 8'h31;
                send_byte(b);
                for (int i = 0; i < HEADER_MAX - 1; i++) begin
                    b = ext_byte(b, i == 0);
                    send_byte(b);
                end
            end
            default: begin
                send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat (8)
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
        endcase
        repeat (6) send_byte(8'($urandom_range(0, 255)));
    endtask

    always begin
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 99) < stall_pct) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: kind %0d data %02h total %0d",
                             m_kind, m_data_byte, m_body_total);
            end else begin
                want = pending_words.pop_front();
                if (m_kind !== want.kind || m_data_byte !== want.data_byte ||
                    m_body_total !== want.body_total) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d: expected kind %0d data %02h total %0d,",
                                 words_seen, want.kind, want.data_byte, want.body_total,
                                 " got kind %0d data %02h total %0d",
                                 m_kind, m_data_byte, m_body_total);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        reset_decoder();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_minimal_chunk();
        test_extension_digits();
        test_lone_cr_bare_lf();
        test_full_length_header();
        test_random_chunks(1650);
        idle_en = 1'b0;
        test_random_chunks(1890);
        test_body_end();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d bytes in %0d chunks, checked %0d words, %0d payload bytes",
                 bytes_sent, chunks_sent, words_seen, bcnt);
        $display("body closed by %s, %0d mismatches", end_how.name(), mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/hcbd_pkg.sv
src/hcbd_in_reg.sv
src/hcbd_core.sv
src/hcbd_out_buf.sv
src/http_chunked_body_decoder_unit.sv
tb/sv/http_chunked_body_decoder_unit_test.sv
